/* rtl/core/hcc_pkg.sv */
`timescale 1ns / 1ps

package hcc_pkg;

    // Default sizes of the edge table and the vertex set
    localparam int MAX_VERTICES_DEF = 256;
    localparam int MAX_EDGES_DEF    = 1024;

    // Fixed field widths
    localparam int IDX_W    = 11;
    localparam int VTX_W    = 8;
    localparam int VCOUNT_W = 9;
    localparam int FAIL_W   = 3;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [IDX_W-1:0] COUNT_MAX = 11'h7FF;

    // Item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_PATH = 1'b1;

    // Failure codes
    localparam logic [FAIL_W-1:0] FAIL_NONE    = 3'd0;
    localparam logic [FAIL_W-1:0] FAIL_GRAPH   = 3'd1;
    localparam logic [FAIL_W-1:0] FAIL_LENGTH  = 3'd2;
    localparam logic [FAIL_W-1:0] FAIL_RANGE   = 3'd3;
    localparam logic [FAIL_W-1:0] FAIL_CONNECT = 3'd4;
    localparam logic [FAIL_W-1:0] FAIL_REPEAT  = 3'd5;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_GRAPH_VALID  = 2'd0;
    localparam logic [1:0] REG_VERTEX_COUNT = 2'd1;
    localparam logic [1:0] REG_EDGE_COUNT   = 2'd2;

    typedef struct packed {
        logic                graph_valid;
        logic [VCOUNT_W-1:0] vertex_count;
        logic [IDX_W-1:0]    edge_count;
    } hcc_cfg_t;

    // One classified item as it waits in the queue
    typedef struct packed {
        logic             kind;
        logic             idx_ok;
        logic [IDX_W-1:0] edge_index;
        logic [VTX_W-1:0] edge_from;
        logic [VTX_W-1:0] edge_to;
        logic             last;
    } hcc_item_t;

    // Keep the smallest nonzero code
    function automatic logic [FAIL_W-1:0] fail_merge(input logic [FAIL_W-1:0] cur,
                                                     input logic [FAIL_W-1:0] code);
        logic [FAIL_W-1:0] res;
        res = cur;
        if (code != FAIL_NONE && (cur == FAIL_NONE || code < cur))
        begin
            res = code;
        end
        return res;
    endfunction

endpackage

/* rtl/core/hcc_ram.sv */
`timescale 1ns / 1ps

module hcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/hcc_front.sv */
`timescale 1ns / 1ps

module hcc_front
    import hcc_pkg::*;
#(
    parameter int MAX_EDGES = MAX_EDGES_DEF
) (
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             kind,
    input  logic [IDX_W-1:0] edge_index,
    input  logic [VTX_W-1:0] edge_from,
    input  logic [VTX_W-1:0] edge_to,
    input  logic             last,
    input  hcc_cfg_t         cfg,
    input  logic             q_full,
    output logic             push,
    output hcc_item_t        push_item
);

    logic [31:0] idx_wide;
    logic        slot_ok;

    always_comb
    begin
        idx_wide = 32'(edge_index);
        slot_ok  = idx_wide < 32'(MAX_EDGES);

        push_item.kind       = kind;
        push_item.edge_index = edge_index;
        push_item.edge_from  = edge_from;
        push_item.edge_to    = edge_to;
        push_item.last       = last;
        // loads need a real slot, path steps also need a loaded edge
        if (kind == KIND_PATH)
        begin
            push_item.idx_ok = slot_ok && (edge_index < cfg.edge_count);
        end
        else
        begin
            push_item.idx_ok = slot_ok;
        end

        in_stall = q_full;
        push     = in_valid && !q_full;
    end

endmodule

/* rtl/core/hcc_queue.sv */
`timescale 1ns / 1ps

module hcc_queue
    import hcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  hcc_item_t push_item,
    output logic      full,
    output logic      q_valid,
    output hcc_item_t q_item,
    input  logic      pop
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    hcc_item_t         entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        r = (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
        return r;
    endfunction

    always_comb
    begin
        full    = (32'(count_reg) == QUEUE_DEPTH);
        q_valid = (count_reg != '0);
        q_item  = entry_reg[rd_ptr_reg];

        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/core/hcc_back.sv */
`timescale 1ns / 1ps

module hcc_back
    import hcc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  hcc_cfg_t          cfg,
    input  logic              q_valid,
    input  hcc_item_t         q_item,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              path_ok,
    output logic [FAIL_W-1:0] fail_reason
);

    localparam int EW = $clog2(MAX_EDGES);
    localparam int VW = $clog2(MAX_VERTICES);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                    state_reg, state_next;
    hcc_item_t               item_reg;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [IDX_W-1:0]        path_count_reg, path_count_next;
    logic [VTX_W-1:0]        start_vertex_reg, start_vertex_next;
    logic [VTX_W-1:0]        prev_dest_reg, prev_dest_next;
    logic [FAIL_W-1:0]       first_fail_reg, first_fail_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    path_ok_reg;
    logic [FAIL_W-1:0]       fail_reason_reg;

    logic [31:0]       pop_idx_wide;
    logic [EW-1:0]     ram_addr;
    logic              ram_we, ram_re;
    logic [VTX_W-1:0]  src_rd, dst_rd;

    logic              first, dst_ok, seen, out_free, exec_done, load_out;
    logic [31:0]       dst_wide;
    logic [VW-1:0]     dst_idx;
    logic [VTX_W-1:0]  start_eff;
    logic [IDX_W-1:0]  count_inc;
    logic [FAIL_W-1:0] fail_acc, verdict;

    // Table access at pop time: loads write, path steps issue the read
    always_comb
    begin
        q_pop        = (state_reg == ST_IDLE) && q_valid;
        pop_idx_wide = 32'(q_item.edge_index);
        ram_addr     = pop_idx_wide[EW-1:0];
        ram_we       = q_pop && (q_item.kind == KIND_LOAD) && q_item.idx_ok;
        ram_re       = q_pop && (q_item.kind == KIND_PATH) && q_item.idx_ok;
    end

    hcc_ram #(.WIDTH(VTX_W), .DEPTH(MAX_EDGES)) u_from_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (q_item.edge_from),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (src_rd)
    );

    hcc_ram #(.WIDTH(VTX_W), .DEPTH(MAX_EDGES)) u_to_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (q_item.edge_to),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (dst_rd)
    );

    // Check the path step against the edge read back
    always_comb
    begin
        first     = (path_count_reg == '0);
        count_inc = (path_count_reg == COUNT_MAX) ? path_count_reg
                                                  : path_count_reg + 1'b1;
        start_eff = first ? src_rd : start_vertex_reg;
        dst_wide  = 32'(dst_rd);
        dst_idx   = dst_wide[VW-1:0];
        dst_ok    = (dst_wide < 32'(cfg.vertex_count)) && (dst_wide < 32'(MAX_VERTICES));
        seen      = visited_reg[dst_idx];

        fail_acc = first_fail_reg;
        if (!item_reg.idx_ok)
        begin
            fail_acc = fail_merge(fail_acc, FAIL_RANGE);
        end
        else
        begin
            if (!first && (src_rd != prev_dest_reg))
            begin
                fail_acc = fail_merge(fail_acc, FAIL_CONNECT);
            end
            if (item_reg.last && (dst_rd != start_eff))
            begin
                fail_acc = fail_merge(fail_acc, FAIL_CONNECT);
            end
            if (!dst_ok)
            begin
                fail_acc = fail_merge(fail_acc, FAIL_RANGE);
            end
            else if (seen)
            begin
                fail_acc = fail_merge(fail_acc, FAIL_REPEAT);
            end
        end

        if (!cfg.graph_valid)
        begin
            verdict = FAIL_GRAPH;
        end
        else if (count_inc != IDX_W'(cfg.vertex_count))
        begin
            verdict = FAIL_LENGTH;
        end
        else
        begin
            verdict = fail_acc;
        end

        out_free  = !out_valid_reg || !out_stall;
        exec_done = (state_reg == ST_EXEC) && (!item_reg.last || out_free);
        load_out  = exec_done && item_reg.last;
    end

    // Next state
    always_comb
    begin
        state_next        = state_reg;
        visited_next      = visited_reg;
        path_count_next   = path_count_reg;
        start_vertex_next = start_vertex_reg;
        prev_dest_next    = prev_dest_reg;
        first_fail_next   = first_fail_reg;
        out_valid_next    = out_valid_reg && out_stall;

        if (q_pop && (q_item.kind == KIND_PATH))
        begin
            state_next = ST_EXEC;
        end

        if (exec_done)
        begin
            state_next = ST_IDLE;
            if (item_reg.last)
            begin
                // verdict out, path state back to empty
                visited_next      = '0;
                path_count_next   = '0;
                start_vertex_next = '0;
                prev_dest_next    = '0;
                first_fail_next   = FAIL_NONE;
                out_valid_next    = 1'b1;
            end
            else
            begin
                path_count_next = count_inc;
                first_fail_next = fail_acc;
                if (item_reg.idx_ok)
                begin
                    if (first)
                    begin
                        start_vertex_next = src_rd;
                    end
                    prev_dest_next = dst_rd;
                    if (dst_ok && !seen)
                    begin
                        visited_next[dst_idx] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            visited_reg      <= '0;
            path_count_reg   <= '0;
            start_vertex_reg <= '0;
            prev_dest_reg    <= '0;
            first_fail_reg   <= FAIL_NONE;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            visited_reg      <= visited_next;
            path_count_reg   <= path_count_next;
            start_vertex_reg <= start_vertex_next;
            prev_dest_reg    <= prev_dest_next;
            first_fail_reg   <= first_fail_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        if (load_out)
        begin
            path_ok_reg     <= (verdict == FAIL_NONE);
            fail_reason_reg <= verdict;
        end
    end

    assign out_valid   = out_valid_reg;
    assign path_ok     = path_ok_reg;
    assign fail_reason = fail_reason_reg;

endmodule

/* rtl/core/hamiltonian_cycle_checker_top.sv */
// Hamiltonian cycle checker: edge table loads and path steps in, one verdict per path out.
// A verdict shows on out_valid after its last path transaction passes the queue, table read
// and check. Back end: a path transaction reads the edge table, then checks and updates the
// visited set; a load only writes the table. A 2-entry queue sits in between.
// Reset (rst_n low, async): registers, queue and path state clear; edge table stays unknown.
`timescale 1ns / 1ps

module hamiltonian_cycle_checker_top
    import hcc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,

    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,

    // input transactions
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic [IDX_W-1:0]   edge_index,
    input  logic [VTX_W-1:0]   edge_from,
    input  logic [VTX_W-1:0]   edge_to,
    input  logic               last,

    // verdict transactions
    output logic               out_valid,
    input  logic               out_stall,
    output logic               path_ok,
    output logic [FAIL_W-1:0]  fail_reason
);

    hcc_cfg_t  cfg_reg, cfg_next;
    logic      cfg_wr;
    logic      q_full, q_valid, q_pop, push;
    hcc_item_t push_item, q_item;

    // Register file: written on the access phase, read back at any time.
    // Writes are expected only while the block is idle, so the front and
    // back ends read the registers directly.
    always_comb
    begin
        pready   = 1'b1;
        cfg_wr   = psel && penable && pwrite && pready;
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_GRAPH_VALID:  cfg_next.graph_valid  = pwdata[0];
                REG_VERTEX_COUNT: cfg_next.vertex_count = pwdata[VCOUNT_W-1:0];
                REG_EDGE_COUNT:   cfg_next.edge_count   = pwdata[IDX_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end

        case (paddr[3:2])
            REG_GRAPH_VALID:  prdata = PDATA_W'(cfg_reg.graph_valid);
            REG_VERTEX_COUNT: prdata = PDATA_W'(cfg_reg.vertex_count);
            REG_EDGE_COUNT:   prdata = PDATA_W'(cfg_reg.edge_count);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: take the transaction, range-check the index, queue it
    hcc_front #(.MAX_EDGES(MAX_EDGES)) u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .edge_index (edge_index),
        .edge_from  (edge_from),
        .edge_to    (edge_to),
        .last       (last),
        .cfg        (cfg_reg),
        .q_full     (q_full),
        .push       (push),
        .push_item  (push_item)
    );

    // Decouple: the front keeps taking items while the back waits on a verdict
    hcc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (q_pop)
    );

    // Back end: edge table, visited set, path checks and the verdict register
    hcc_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .path_ok     (path_ok),
        .fail_reason (fail_reason)
    );

endmodule

/* rtl/core/hcc_checker.sv */
`timescale 1ns / 1ps

module hcc_checker
    import hcc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic              path_ok,
    input logic [FAIL_W-1:0] fail_reason
);

    // a stalled verdict stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("verdict dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(path_ok) && $stable(fail_reason))
        else $error("verdict changed while stalled");

    // pass flag agrees with the code
    a_ok_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (path_ok == (fail_reason == FAIL_NONE)))
        else $error("path_ok disagrees with fail_reason");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fail_reason <= FAIL_REPEAT))
        else $error("fail_reason out of range");

    // no verdict straight out of reset
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("verdict present right after reset");

endmodule

bind hamiltonian_cycle_checker_top hcc_checker u_hcc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .path_ok     (path_ok),
    .fail_reason (fail_reason)
);
